@@ hw/rtl/epmt_pkg.sv @@
// Shared types, constants and helpers for the encoder multiturn tracker.
// Used by the front stage, the item queue, the back stage and the top level.
package epmt_pkg;

  localparam int WORD_W        = 16;
  localparam int DATA_W        = 14;
  localparam int RES_W         = 15;
  localparam int TOTAL_W       = 31;
  localparam int TOTAL_OUT_W   = 30;
  localparam int TURN_OUT_W    = 16;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam int POSITION_BITS_DEF = 14;
  localparam int TURN_BITS_DEF     = 16;
  localparam int FIFO_DEPTH        = 2;

  localparam logic [RES_W-1:0]  RES_RESET = 15'd16384;
  localparam logic [DATA_W-1:0] ODD_MASK  = 14'h2AAA;
  localparam logic [DATA_W-1:0] EVEN_MASK = 14'h1555;

  // Register index, taken from paddr bit 2 (word-aligned registers)
  localparam logic REG_ENABLE     = 1'b0;
  localparam logic REG_RESOLUTION = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
  } epmt_item_t;

  typedef struct packed {
    logic             enable;
    logic [RES_W-1:0] resolution;
  } epmt_cfg_t;

  // Both check bits are odd parity: check bit is the inverse of the XOR.
  function automatic logic parity_good(input logic [WORD_W-1:0] w);
    logic odd_x;
    logic even_x;
    odd_x  = ^(w[DATA_W-1:0] & ODD_MASK);
    even_x = ^(w[DATA_W-1:0] & EVEN_MASK);
    return (w[15] == ~odd_x) && (w[14] == ~even_x);
  endfunction

endpackage

@@ hw/rtl/epmt_front.sv @@
// Front stage: registers each encoder word and classifies it by its check bits.
// Depends on epmt_pkg; feeds the item queue.
module epmt_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [epmt_pkg::WORD_W-1:0]    in_raw_word,
  output logic                           push_valid,
  input  logic                           push_ready,
  output epmt_pkg::epmt_item_t           push_item
);
  import epmt_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  epmt_item_t item_r;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.ok   <= parity_good(in_raw_word);
      item_r.data <= in_raw_word[DATA_W-1:0];
    end
  end

endmodule

@@ hw/rtl/epmt_fifo.sv @@
// Short queue between the front and back stages of the tracker.
// Depends on epmt_pkg for the item type and depth.
module epmt_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  epmt_pkg::epmt_item_t  push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output epmt_pkg::epmt_item_t  pop_item
);
  import epmt_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  epmt_item_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/epmt_back.sv @@
// Back stages: position and turn update, then turn scaling into the total count.
// Depends on epmt_pkg; drives the result channel through its output register.
module epmt_back #(
  parameter int POSITION_BITS = epmt_pkg::POSITION_BITS_DEF,
  parameter int TURN_BITS     = epmt_pkg::TURN_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  epmt_pkg::epmt_cfg_t                     cfg,
  input  logic                                    pop_valid,
  output logic                                    pop_ready,
  input  epmt_pkg::epmt_item_t                    pop_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_not_ready,
  output logic                                    out_parity_ok,
  output logic [epmt_pkg::DATA_W-1:0]             out_abs_position,
  output logic signed [epmt_pkg::TURN_OUT_W-1:0]  out_turn_count,
  output logic signed [epmt_pkg::TOTAL_OUT_W-1:0] out_total_count
);
  import epmt_pkg::*;

  // tracker state
  logic [POSITION_BITS-1:0]    pos_r, pos_nxt;
  logic signed [TURN_BITS-1:0] turns_r, turns_nxt;
  logic [TOTAL_W-1:0]          total_r, total_nxt;

  // update stage
  logic                        s1_valid_r;
  logic                        s1_en_r;
  logic                        s1_ok_r;
  logic [POSITION_BITS-1:0]    s1_pos_r;
  logic signed [TURN_BITS-1:0] s1_turns_r;

  // output register
  logic                        out_valid_r;
  logic                        out_not_ready_r;
  logic                        out_parity_ok_r;
  logic [DATA_W-1:0]           out_abs_position_r;
  logic [TURN_OUT_W-1:0]       out_turn_count_r;
  logic [TOTAL_OUT_W-1:0]      out_total_count_r;

  logic                        out_adv;
  logic                        s1_load;
  logic                        out_load;
  logic                        take;
  logic [POSITION_BITS-1:0]    pos_new;
  logic [POSITION_BITS-1:0]    diff;
  logic [RES_W+1:0]            thr_x3;
  logic [RES_W-1:0]            thr;
  logic                        fell;
  logic                        turn_hit;
  logic [TOTAL_W-1:0]          turns_wide;
  logic [TOTAL_W-1:0]          scaled;

  assign out_adv   = !out_valid_r || out_ready;
  assign pop_ready = !s1_valid_r || out_adv;
  assign s1_load   = pop_valid && pop_ready;
  assign out_load  = s1_valid_r && out_adv;

  // Position and turn update for the word at the head of the queue
  always_comb begin
    take     = cfg.enable && pop_item.ok;
    pos_new  = take ? pop_item.data[POSITION_BITS-1:0] : pos_r;
    fell     = pos_r > pos_new;
    diff     = fell ? (pos_r - pos_new) : (pos_new - pos_r);
    thr_x3   = {2'b00, cfg.resolution} + {1'b0, cfg.resolution, 1'b0};
    thr      = thr_x3[RES_W+1:2];
    turn_hit = (RES_W'(diff) >= thr) && (pos_r != pos_new);
    pos_nxt   = pos_r;
    turns_nxt = turns_r;
    if (cfg.enable) begin
      pos_nxt = pos_new;
      if (turn_hit) begin
        turns_nxt = fell ? (turns_r + TURN_BITS'(1)) : (turns_r - TURN_BITS'(1));
      end
    end
  end

  // Scale turns by resolution; only the low total bits are kept, so wrap is free
  always_comb begin
    turns_wide = TOTAL_W'(s1_turns_r);
    scaled     = TOTAL_W'(turns_wide * TOTAL_W'(cfg.resolution));
    total_nxt  = s1_en_r ? (scaled + TOTAL_W'(s1_pos_r)) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      turns_r     <= '0;
      total_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        pos_r   <= pos_nxt;
        turns_r <= turns_nxt;
      end
      if (out_load) begin
        total_r <= total_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_en_r    <= cfg.enable;
      s1_ok_r    <= take;
      s1_pos_r   <= pos_nxt;
      s1_turns_r <= turns_nxt;
    end
    if (out_load) begin
      out_not_ready_r    <= !s1_en_r;
      out_parity_ok_r    <= s1_ok_r;
      out_abs_position_r <= DATA_W'(s1_pos_r);
      out_turn_count_r   <= TURN_OUT_W'(s1_turns_r);
      out_total_count_r  <= total_nxt[TOTAL_OUT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_not_ready    = out_not_ready_r;
  assign out_parity_ok    = out_parity_ok_r;
  assign out_abs_position = out_abs_position_r;
  assign out_turn_count   = $signed(out_turn_count_r);
  assign out_total_count  = $signed(out_total_count_r);

endmodule

@@ hw/rtl/encoder_parity_multiturn_tracker_core.sv @@
// Top level of the encoder multiturn tracker: register port, front stage,
// item queue and back stages. Depends on epmt_pkg, epmt_front, epmt_fifo, epmt_back.
//
// Usage:
//   in_valid/in_ready carry one 16-bit encoder word per transfer; each word
//   yields exactly one result word on out_valid/out_ready (status flags,
//   single-turn position, turn count and total count).
//   Throughput is one word per cycle while out_ready stays high: the front
//   register, the two-entry queue, the update stage and the output register
//   each pass one word a cycle. A taken word passes the front register, the
//   queue, the update stage and then the output register, where out_valid
//   rises. The turn update and the turn scaling multiply sit in separate stages.
//   A stalled receiver holds the output register; the queue and the front
//   register keep absorbing words until they fill, then in_ready drops.
//   Registers (APB, always ready): 0x0 enable (bit 0), 0x4 resolution (14:0).
//   Write them only while no word is in flight. While enable is 0 every word
//   still gets a result with not_ready set and the held state.
//   Reset (rst_n low, synchronous) clears position, turns and total, empties
//   the pipeline, sets enable to 0 and resolution to 16384.
module encoder_parity_multiturn_tracker_core #(
  parameter int POSITION_BITS = epmt_pkg::POSITION_BITS_DEF,
  parameter int TURN_BITS     = epmt_pkg::TURN_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [epmt_pkg::WORD_W-1:0]             in_raw_word,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_not_ready,
  output logic                                    out_parity_ok,
  output logic [epmt_pkg::DATA_W-1:0]             out_abs_position,
  output logic signed [epmt_pkg::TURN_OUT_W-1:0]  out_turn_count,
  output logic signed [epmt_pkg::TOTAL_OUT_W-1:0] out_total_count,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [epmt_pkg::CFG_ADDR_W-1:0]         cfg_paddr,
  input  logic [epmt_pkg::CFG_DATA_W-1:0]         cfg_pwdata,
  output logic [epmt_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                    cfg_pready
);
  import epmt_pkg::*;

  localparam int INFLIGHT_MAX = FIFO_DEPTH + 3;
  localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);

  logic             enable_r, enable_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic             cfg_wr;
  logic             reg_idx;
  epmt_cfg_t        cfg;

  logic       push_valid, push_ready;
  epmt_item_t push_item;
  logic       pop_valid, pop_ready;
  epmt_item_t pop_item;

  logic [INFLIGHT_W-1:0] inflight_r, inflight_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    enable_nxt = enable_r;
    res_nxt    = res_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLE:     enable_nxt = cfg_pwdata[0];
        REG_RESOLUTION: res_nxt    = cfg_pwdata[RES_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:     cfg_prdata = CFG_DATA_W'(enable_r);
      REG_RESOLUTION: cfg_prdata = CFG_DATA_W'(res_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      res_r    <= RES_RESET;
    end else begin
      enable_r <= enable_nxt;
      res_r    <= res_nxt;
    end
  end

  assign cfg.enable     = enable_r;
  assign cfg.resolution = res_r;

  epmt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw_word (in_raw_word),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  epmt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  epmt_back #(
    .POSITION_BITS (POSITION_BITS),
    .TURN_BITS     (TURN_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_not_ready    (out_not_ready),
    .out_parity_ok    (out_parity_ok),
    .out_abs_position (out_abs_position),
    .out_turn_count   (out_turn_count),
    .out_total_count  (out_total_count)
  );

  // Words taken but not yet delivered
  always_comb begin
    inflight_nxt = inflight_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      inflight_nxt = inflight_r + INFLIGHT_W'(1);
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      inflight_nxt = inflight_r - INFLIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inflight_r != '0))
    else $error("result presented with no word in flight");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= INFLIGHT_W'(INFLIGHT_MAX))
    else $error("more words in flight than pipeline holds");

  a_disabled_no_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_ready) |-> !out_parity_ok)
    else $error("parity_ok reported while disabled");

  a_empty_no_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == '0) |-> in_ready)
    else $error("input stalled with an empty pipeline");

endmodule
